### design/sgfl_pkg.sv
// ----------------------------------------------------------------------------
// sgfl_pkg
// Shared constants, command codes and controller/datapath interface types
// for the scatter-gather fragment list.
// ----------------------------------------------------------------------------
package sgfl_pkg;

  localparam int TOTAL_BITS = 28;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 28'hFFF_FFFF;

  localparam int CMD_BITS = 3;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_APPEND  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_INSERT  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_EXTRACT = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_COPY    = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_REWIND  = 3'd5;

  typedef struct packed {
    logic load;
    logic clear_all;
    logic append;
    logic ins_put;
    logic idx_from_count;
    logic shift_rd;
    logic shift_wr;
    logic rewind_init;
    logic sum_rd;
    logic sum_acc;
    logic slot_rd;
    logic ext_step;
    logic cp_advance;
    logic cp_calc;
    logic cp_emit;
    logic emit;
    logic emit_ok;
    logic emit_last;
    logic emit_ext;
    logic emit_seg;
    logic emit_pad;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_append;
    logic is_insert;
    logic is_extract;
    logic is_copy;
    logic is_rewind;
    logic frag_nonempty;
    logic full;
    logic count_zero;
    logic want_zero;
    logic slot_used;
    logic off_ge_len;
    logic idx_zero;
    logic idx_last;
    logic fin;
  } dp_status_t;

endpackage

### design/sgfl_ram.sv
// ----------------------------------------------------------------------------
// sgfl_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sgfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/sgfl_dpath.sv
// ----------------------------------------------------------------------------
// sgfl_dpath
// Datapath: descriptor RAM, fill count, read position, running byte total,
// copy segment arithmetic and result registers.
// ----------------------------------------------------------------------------
module sgfl_dpath #(
  parameter int SLOTS        = 16,
  parameter int LENGTH_BITS  = 24,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [sgfl_pkg::CMD_BITS-1:0]     command,
  input  logic [ADDRESS_BITS-1:0]           frag_address,
  input  logic [LENGTH_BITS-1:0]            byte_count,
  input  sgfl_pkg::ctrl_cmd_t               cmd,
  output sgfl_pkg::dp_status_t              st,
  output logic                              result_valid,
  output logic                              accepted,
  output logic [ADDRESS_BITS-1:0]           seg_address,
  output logic [LENGTH_BITS-1:0]            seg_length,
  output logic                              seg_is_pad,
  output logic [$clog2(SLOTS+1)-1:0]        entries_left,
  output logic [LENGTH_BITS-1:0]            copied_bytes,
  output logic [sgfl_pkg::TOTAL_BITS-1:0]   size_bytes,
  output logic                              last
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(SLOTS);
  localparam int EW = ADDRESS_BITS + LENGTH_BITS;
  localparam int TB = sgfl_pkg::TOTAL_BITS;
  localparam int SW = (LENGTH_BITS > TB ? LENGTH_BITS : TB) + 1;
  localparam int MW = (LENGTH_BITS > ADDRESS_BITS ? LENGTH_BITS : ADDRESS_BITS);

  function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] t,
                                            input logic [LENGTH_BITS-1:0] v);
    logic [SW-1:0] s;
    s = SW'(t) + SW'(v);
    if (s > SW'(sgfl_pkg::TOTAL_MAX)) begin
      return sgfl_pkg::TOTAL_MAX;
    end
    return s[TB-1:0];
  endfunction

  function automatic logic [TB-1:0] sat_sub(input logic [TB-1:0] t,
                                            input logic [LENGTH_BITS-1:0] v);
    logic [SW-1:0] tw;
    logic [SW-1:0] vw;
    logic [SW-1:0] d;
    tw = SW'(t);
    vw = SW'(v);
    d  = tw - vw;
    if (vw >= tw) begin
      return '0;
    end
    return d[TB-1:0];
  endfunction

  logic [sgfl_pkg::CMD_BITS-1:0] cmd_code;
  logic [ADDRESS_BITS-1:0]       addr_in;
  logic [LENGTH_BITS-1:0]        len_in;
  logic [LENGTH_BITS-1:0]        want;
  logic [LENGTH_BITS-1:0]        copied;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 read_slot;
  logic [LENGTH_BITS-1:0]        offset;
  logic [TB-1:0]                 total;
  logic [TB-1:0]                 total_next;
  logic [IW-1:0]                 idx;
  logic [IW-1:0]                 rd_q;
  logic                          pend;
  logic [LENGTH_BITS-1:0]        take;
  logic [ADDRESS_BITS-1:0]       seg_addr;
  logic                          fin;

  logic                          wr_en;
  logic [IW-1:0]                 wr_addr;
  logic [EW-1:0]                 wr_data;
  logic [IW-1:0]                 rd_addr;
  logic [EW-1:0]                 rd_data;
  logic [LENGTH_BITS-1:0]        rd_len;
  logic [ADDRESS_BITS-1:0]       rd_adr;

  logic                          slot_used;
  logic                          in_table;
  logic [CW-1:0]                 rs_inc;
  logic [CW-1:0]                 cm1;
  logic [CW-1:0]                 left;
  logic [ADDRESS_BITS-1:0]       ext_a;
  logic [LENGTH_BITS-1:0]        ext_l;
  logic [LENGTH_BITS-1:0]        avail;
  logic [LENGTH_BITS-1:0]        take_calc;
  logic [MW-1:0]                 addr_sum;
  logic [LENGTH_BITS-1:0]        copied_sum;
  logic [LENGTH_BITS-1:0]        add_opd;
  logic [LENGTH_BITS-1:0]        sub_opd;
  logic [TB-1:0]                 add_res;
  logic [TB-1:0]                 sub_res;

  sgfl_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_len     = rd_data[LENGTH_BITS-1:0];
  assign rd_adr     = rd_data[EW-1:LENGTH_BITS];
  assign rd_addr    = cmd.slot_rd ? read_slot[IW-1:0] : idx;

  assign slot_used  = read_slot < count;
  assign in_table   = read_slot < CW'(SLOTS);
  assign rs_inc     = read_slot + CW'(1);
  assign cm1        = count - CW'(1);
  assign left       = (in_table && count > rs_inc) ? count - rs_inc : '0;
  assign ext_a      = slot_used ? rd_adr : '0;
  assign ext_l      = slot_used ? rd_len : '0;
  assign avail      = rd_len - offset;
  assign take_calc  = (avail < want) ? avail : want;
  assign addr_sum   = MW'(rd_adr) + MW'(offset);
  assign copied_sum = copied + take;

  assign add_opd    = cmd.sum_acc ? rd_len : len_in;
  assign sub_opd    = cmd.cp_emit ? take : ext_l;
  assign add_res    = sat_add(total, add_opd);
  assign sub_res    = sat_sub(total, sub_opd);

  always_comb begin
    total_next = total;
    priority if (cmd.clear_all || cmd.rewind_init) begin
      total_next = '0;
    end else if (cmd.append || cmd.ins_put || (cmd.sum_acc && pend)) begin
      total_next = add_res;
    end else if (cmd.ext_step || cmd.cp_emit) begin
      total_next = sub_res;
    end else begin
      total_next = total;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = {addr_in, len_in};
    priority if (cmd.append) begin
      wr_en   = 1'b1;
      wr_addr = count[IW-1:0];
    end else if (cmd.ins_put) begin
      wr_en   = 1'b1;
    end else if (cmd.shift_wr && pend) begin
      wr_en   = 1'b1;
      wr_addr = rd_q + IW'(1);
      wr_data = rd_data;
    end else begin
      wr_en   = 1'b0;
    end
  end

  always_comb begin
    st               = '0;
    st.is_clear      = cmd_code == sgfl_pkg::CMD_CLEAR;
    st.is_append     = cmd_code == sgfl_pkg::CMD_APPEND;
    st.is_insert     = cmd_code == sgfl_pkg::CMD_INSERT;
    st.is_extract    = cmd_code == sgfl_pkg::CMD_EXTRACT;
    st.is_copy       = cmd_code == sgfl_pkg::CMD_COPY;
    st.is_rewind     = cmd_code == sgfl_pkg::CMD_REWIND;
    st.frag_nonempty = (addr_in != '0) && (len_in != '0);
    st.full          = count == CW'(SLOTS);
    st.count_zero    = count == '0;
    st.want_zero     = want == '0;
    st.slot_used     = slot_used;
    st.off_ge_len    = offset >= rd_len;
    st.idx_zero      = idx == '0;
    st.idx_last      = CW'(idx) == cm1;
    st.fin           = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      read_slot    <= '0;
      offset       <= '0;
      total        <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      total        <= total_next;
      if (cmd.load) begin
        pend <= 1'b0;
      end else if (cmd.shift_rd || cmd.sum_rd) begin
        pend <= 1'b1;
      end
      if (cmd.clear_all) begin
        count <= '0;
      end else if (cmd.append || cmd.ins_put) begin
        count <= count + CW'(1);
      end
      priority if (cmd.clear_all || cmd.rewind_init) begin
        read_slot <= '0;
        offset    <= '0;
      end else if (cmd.ext_step && in_table) begin
        read_slot <= rs_inc;
        offset    <= '0;
      end else if (cmd.cp_advance || (cmd.cp_emit && !fin)) begin
        read_slot <= rs_inc;
        offset    <= '0;
      end else if (cmd.cp_emit) begin
        offset <= offset + take;
      end else begin
        read_slot <= read_slot;
        offset    <= offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_code <= command;
      addr_in  <= frag_address;
      len_in   <= byte_count;
      want     <= byte_count;
      copied   <= '0;
    end
    if (cmd.idx_from_count) begin
      idx <= cm1[IW-1:0];
    end else if (cmd.rewind_init) begin
      idx <= '0;
    end else if (cmd.shift_rd) begin
      idx <= idx - IW'(1);
    end else if (cmd.sum_rd) begin
      idx <= idx + IW'(1);
    end
    if (cmd.shift_rd || cmd.sum_rd) begin
      rd_q <= idx;
    end
    if (cmd.cp_calc) begin
      take     <= take_calc;
      seg_addr <= addr_sum[ADDRESS_BITS-1:0];
      fin      <= (want <= avail);
    end
    if (cmd.cp_emit) begin
      want   <= want - take;
      copied <= copied_sum;
    end
    if (cmd.emit) begin
      accepted   <= cmd.emit_ok;
      last       <= cmd.emit_last;
      size_bytes <= total_next;
      seg_is_pad <= cmd.emit_pad;
      seg_address <= cmd.emit_ext ? ext_a : (cmd.emit_seg ? seg_addr : '0);
      seg_length  <= cmd.emit_ext ? ext_l :
                     (cmd.emit_seg ? take : (cmd.emit_pad ? want : '0));
      entries_left <= cmd.emit_ext ? left : '0;
      copied_bytes <= cmd.emit_seg ? copied_sum : (cmd.emit_pad ? copied : '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SLOTS))
    else $error("fill count beyond table size");

  a_read_slot_bound: assert property (@(posedge clk) disable iff (rst)
    read_slot <= CW'(SLOTS))
    else $error("read slot beyond table size");

endmodule

### design/sgfl_ctrl.sv
// ----------------------------------------------------------------------------
// sgfl_ctrl
// Controller: decodes the held command and sequences RAM sweeps, copy
// segment steps and result strobes.
// ----------------------------------------------------------------------------
module sgfl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sgfl_pkg::dp_status_t st,
  output sgfl_pkg::ctrl_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DISPATCH   = 4'd1;
  localparam logic [3:0] S_SHIFT      = 4'd2;
  localparam logic [3:0] S_SHIFT_LAST = 4'd3;
  localparam logic [3:0] S_INS_PUT    = 4'd4;
  localparam logic [3:0] S_SUM        = 4'd5;
  localparam logic [3:0] S_SUM_LAST   = 4'd6;
  localparam logic [3:0] S_EXT        = 4'd7;
  localparam logic [3:0] S_CP_RD      = 4'd8;
  localparam logic [3:0] S_CP_CHK     = 4'd9;
  localparam logic [3:0] S_CP_EMIT    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next    = S_IDLE;
        cmd.emit_last = 1'b1;
        cmd.emit_ok   = 1'b1;
        priority if (st.is_clear) begin
          cmd.clear_all = 1'b1;
          cmd.emit      = 1'b1;
        end else if (st.is_append) begin
          cmd.emit = 1'b1;
          if (st.frag_nonempty) begin
            if (st.full) begin
              cmd.emit_ok = 1'b0;
            end else begin
              cmd.append = 1'b1;
            end
          end
        end else if (st.is_insert) begin
          if (!st.frag_nonempty) begin
            cmd.emit = 1'b1;
          end else if (st.full) begin
            cmd.emit    = 1'b1;
            cmd.emit_ok = 1'b0;
          end else if (st.count_zero) begin
            state_next = S_INS_PUT;
          end else begin
            cmd.idx_from_count = 1'b1;
            state_next         = S_SHIFT;
          end
        end else if (st.is_extract) begin
          cmd.slot_rd = 1'b1;
          state_next  = S_EXT;
        end else if (st.is_copy) begin
          if (st.want_zero) begin
            cmd.emit = 1'b1;
          end else begin
            state_next = S_CP_RD;
          end
        end else if (st.is_rewind) begin
          cmd.rewind_init = 1'b1;
          if (st.count_zero) begin
            cmd.emit = 1'b1;
          end else begin
            state_next = S_SUM;
          end
        end else begin
          cmd.emit    = 1'b1;
          cmd.emit_ok = 1'b0;
        end
      end
      S_SHIFT: begin
        cmd.shift_rd = 1'b1;
        cmd.shift_wr = 1'b1;
        if (st.idx_zero) begin
          state_next = S_SHIFT_LAST;
        end
      end
      S_SHIFT_LAST: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_INS_PUT;
      end
      S_INS_PUT: begin
        cmd.ins_put   = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_ok   = 1'b1;
        cmd.emit_last = 1'b1;
        state_next    = S_IDLE;
      end
      S_SUM: begin
        cmd.sum_rd  = 1'b1;
        cmd.sum_acc = 1'b1;
        if (st.idx_last) begin
          state_next = S_SUM_LAST;
        end
      end
      S_SUM_LAST: begin
        cmd.sum_acc   = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_ok   = 1'b1;
        cmd.emit_last = 1'b1;
        state_next    = S_IDLE;
      end
      S_EXT: begin
        cmd.ext_step  = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_ok   = 1'b1;
        cmd.emit_last = 1'b1;
        cmd.emit_ext  = 1'b1;
        state_next    = S_IDLE;
      end
      S_CP_RD: begin
        if (!st.slot_used) begin
          cmd.emit      = 1'b1;
          cmd.emit_ok   = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_pad  = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.slot_rd = 1'b1;
          state_next  = S_CP_CHK;
        end
      end
      S_CP_CHK: begin
        if (st.off_ge_len) begin
          cmd.cp_advance = 1'b1;
          state_next     = S_CP_RD;
        end else begin
          cmd.cp_calc = 1'b1;
          state_next  = S_CP_EMIT;
        end
      end
      S_CP_EMIT: begin
        cmd.cp_emit   = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_ok   = 1'b1;
        cmd.emit_seg  = 1'b1;
        cmd.emit_last = st.fin;
        state_next    = st.fin ? S_IDLE : S_CP_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_start_dispatch: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> state == S_DISPATCH)
    else $error("accepted item not dispatched");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_last) |=> state == S_IDLE)
    else $error("final result without return to idle");

  a_shift_room: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_rd |-> !st.full)
    else $error("shift started on a full table");

endmodule

### design/scatter_gather_fragment_list.sv
// ----------------------------------------------------------------------------
// scatter_gather_fragment_list
// Fragment descriptor table with append, insert-front, extract, copy
// (as address/length segments) and rewind commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every result appears
// for exactly one cycle with result_valid high, and last marks the final
// result of a command; the receiver cannot stall. All descriptors live in
// one single-port-read RAM, so busy time follows the number of entries
// touched. Clear, append, unknown codes, an empty or refused insert, a
// zero-byte copy and a rewind of an empty list end in the dispatch step;
// extract reads the slot and emits; insert shifts the n > 0 entries up one
// slot, last first, then writes the front; rewind sums the n entries; copy
// reads each fragment, skips used-up ones, emits segments and a pad if the
// list runs out. Each result strobes the cycle after the step that makes it.
// ----------------------------------------------------------------------------
module scatter_gather_fragment_list #(
  parameter int SLOTS        = 16,
  parameter int LENGTH_BITS  = 24,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [sgfl_pkg::CMD_BITS-1:0]   command,
  input  logic [ADDRESS_BITS-1:0]         frag_address,
  input  logic [LENGTH_BITS-1:0]          byte_count,
  output logic                            result_valid,
  output logic                            accepted,
  output logic [ADDRESS_BITS-1:0]         seg_address,
  output logic [LENGTH_BITS-1:0]          seg_length,
  output logic                            seg_is_pad,
  output logic [$clog2(SLOTS+1)-1:0]      entries_left,
  output logic [LENGTH_BITS-1:0]          copied_bytes,
  output logic [sgfl_pkg::TOTAL_BITS-1:0] size_bytes,
  output logic                            last
);

  sgfl_pkg::ctrl_cmd_t  cmd;
  sgfl_pkg::dp_status_t st;

  sgfl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  sgfl_dpath #(
    .SLOTS        (SLOTS),
    .LENGTH_BITS  (LENGTH_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .command      (command),
    .frag_address (frag_address),
    .byte_count   (byte_count),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .accepted     (accepted),
    .seg_address  (seg_address),
    .seg_length   (seg_length),
    .seg_is_pad   (seg_is_pad),
    .entries_left (entries_left),
    .copied_bytes (copied_bytes),
    .size_bytes   (size_bytes),
    .last         (last)
  );

endmodule

### dv/sgfl_segment_checker.sv
// ----------------------------------------------------------------------------
// sgfl_segment_checker
// Watches the command and result channels of the fragment list. It keeps its
// own descriptor table, read position and byte total, predicts the results of
// every accepted command in order, and compares each strobed result with the
// oldest prediction field by field.
// ----------------------------------------------------------------------------
module sgfl_segment_checker #(
  parameter int SLOTS        = 16,
  parameter int LENGTH_BITS  = 24,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [sgfl_pkg::CMD_BITS-1:0]     command,
  input  logic [ADDRESS_BITS-1:0]           frag_address,
  input  logic [LENGTH_BITS-1:0]            byte_count,
  input  logic                              result_valid,
  input  logic                              accepted,
  input  logic [ADDRESS_BITS-1:0]           seg_address,
  input  logic [LENGTH_BITS-1:0]            seg_length,
  input  logic                              seg_is_pad,
  input  logic [$clog2(SLOTS+1)-1:0]        entries_left,
  input  logic [LENGTH_BITS-1:0]            copied_bytes,
  input  logic [sgfl_pkg::TOTAL_BITS-1:0]   size_bytes,
  input  logic                              last,
  output int                                fail_count,
  output int                                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEFT_BITS = $clog2(SLOTS + 1);
  localparam int TW        = sgfl_pkg::TOTAL_BITS;

  typedef struct packed {
    logic                    ok;
    logic [ADDRESS_BITS-1:0] addr;
    logic [LENGTH_BITS-1:0]  len;
    logic                    pad;
    logic [LEFT_BITS-1:0]    left;
    logic [LENGTH_BITS-1:0]  copied;
    logic [TW-1:0]           size;
    logic                    last;
  } seg_t;

  logic [ADDRESS_BITS-1:0] desc_addr [SLOTS];
  logic [LENGTH_BITS-1:0]  desc_len  [SLOTS];
  int                      rd_slot;
  logic [LENGTH_BITS-1:0]  rd_off;
  logic [TW-1:0]           total_bytes;
  seg_t                    seg_expected [$];

  function automatic logic [TW-1:0] total_plus(logic [TW-1:0] t,
                                               logic [LENGTH_BITS-1:0] v);
    longint unsigned s;
    s = 64'(t) + 64'(v);
    return (s > 64'(sgfl_pkg::TOTAL_MAX)) ? sgfl_pkg::TOTAL_MAX : TW'(s);
  endfunction

  function automatic logic [TW-1:0] total_minus(logic [TW-1:0] t,
                                                logic [LENGTH_BITS-1:0] v);
    if (64'(v) >= 64'(t)) return '0;
    return TW'(64'(t) - 64'(v));
  endfunction

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      desc_addr[i] = '0;
      desc_len[i]  = '0;
    end
    rd_slot     = 0;
    rd_off      = '0;
    total_bytes = '0;
  endtask

  task automatic push_seg(logic ok, logic [ADDRESS_BITS-1:0] a, logic [LENGTH_BITS-1:0] n,
                          logic pad, int left, logic [LENGTH_BITS-1:0] copied);
    seg_t s;
    s.ok     = ok;
    s.addr   = a;
    s.len    = n;
    s.pad    = pad;
    s.left   = LEFT_BITS'(left);
    s.copied = copied;
    s.size   = total_bytes;
    s.last   = 1'b0;
    seg_expected.push_back(s);
  endtask

  task automatic predict_command(logic [sgfl_pkg::CMD_BITS-1:0] op,
                                 logic [ADDRESS_BITS-1:0] a,
                                 logic [LENGTH_BITS-1:0] n);
    int                      count;
    int                      left;
    logic                    ok;
    logic [ADDRESS_BITS-1:0] ext_addr;
    logic [LENGTH_BITS-1:0]  ext_len;
    logic [LENGTH_BITS-1:0]  want;
    logic [LENGTH_BITS-1:0]  copied;
    logic [LENGTH_BITS-1:0]  avail;
    logic [LENGTH_BITS-1:0]  take;
    seg_t                    tail;
    count = seg_expected.size();
    case (op)
      sgfl_pkg::CMD_CLEAR: begin
        clear_table();
        push_seg(1'b1, '0, '0, 1'b0, 0, '0);
      end
      sgfl_pkg::CMD_APPEND: begin
        ok = 1'b1;
        if (a != '0 && n != '0) begin
          ok = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!ok && desc_addr[i] == '0) begin
              desc_addr[i] = a;
              desc_len[i]  = n;
              total_bytes  = total_plus(total_bytes, n);
              ok = 1'b1;
            end
          end
        end
        push_seg(ok, '0, '0, 1'b0, 0, '0);
      end
      sgfl_pkg::CMD_INSERT: begin
        ok = 1'b1;
        if (a != '0 && n != '0) begin
          if (desc_addr[SLOTS-1] == '0) begin
            for (int i = SLOTS - 1; i > 0; i--) begin
              desc_addr[i] = desc_addr[i-1];
              desc_len[i]  = desc_len[i-1];
            end
            desc_addr[0] = a;
            desc_len[0]  = n;
            total_bytes  = total_plus(total_bytes, n);
          end else begin
            ok = 1'b0;
          end
        end
        push_seg(ok, '0, '0, 1'b0, 0, '0);
      end
      sgfl_pkg::CMD_EXTRACT: begin
        ext_addr = '0;
        ext_len  = '0;
        left     = 0;
        if (rd_slot < SLOTS) begin
          ext_addr    = desc_addr[rd_slot];
          ext_len     = desc_len[rd_slot];
          total_bytes = total_minus(total_bytes, ext_len);
          rd_slot++;
          rd_off = '0;
        end
        for (int i = rd_slot; i < SLOTS; i++) begin
          if (desc_addr[i] == '0) break;
          left++;
        end
        push_seg(1'b1, ext_addr, ext_len, 1'b0, left, '0);
      end
      sgfl_pkg::CMD_COPY: begin
        want   = n;
        copied = '0;
        while (want != '0) begin
          if (rd_slot >= SLOTS || desc_addr[rd_slot] == '0) begin
            push_seg(1'b1, '0, want, 1'b1, 0, copied);
            want = '0;
          end else if (rd_off >= desc_len[rd_slot]) begin
            rd_slot++;
            rd_off = '0;
          end else begin
            avail       = desc_len[rd_slot] - rd_off;
            take        = (avail < want) ? avail : want;
            ext_addr    = desc_addr[rd_slot] + ADDRESS_BITS'(rd_off);
            rd_off      = rd_off + take;
            want        = want - take;
            copied      = copied + take;
            total_bytes = total_minus(total_bytes, take);
            push_seg(1'b1, ext_addr, take, 1'b0, 0, copied);
          end
        end
        if (seg_expected.size() == count) push_seg(1'b1, '0, '0, 1'b0, 0, '0);
      end
      sgfl_pkg::CMD_REWIND: begin
        rd_slot     = 0;
        rd_off      = '0;
        total_bytes = '0;
        for (int i = 0; i < SLOTS; i++) begin
          if (desc_addr[i] == '0) break;
          total_bytes = total_plus(total_bytes, desc_len[i]);
        end
        push_seg(1'b1, '0, '0, 1'b0, 0, '0);
      end
      default: begin
        push_seg(1'b0, '0, '0, 1'b0, 0, '0);
      end
    endcase
    tail = seg_expected.pop_back();
    tail.last = 1'b1;
    seg_expected.push_back(tail);
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(what, got, want);
  endtask

  always @(posedge clk) begin
    seg_t want_seg;
    if (rst) begin
      clear_table();
      seg_expected.delete();
      fail_count = 0;
    end else begin
      if (result_valid) begin
        if (seg_expected.size() == 0) begin
          report("result with nothing pending", 64'(seg_address), '0);
        end else begin
          want_seg = seg_expected.pop_front();
          check_field("accepted", 64'(accepted), 64'(want_seg.ok));
          check_field("seg_address", 64'(seg_address), 64'(want_seg.addr));
          check_field("seg_length", 64'(seg_length), 64'(want_seg.len));
          check_field("seg_is_pad", 64'(seg_is_pad), 64'(want_seg.pad));
          check_field("entries_left", 64'(entries_left), 64'(want_seg.left));
          check_field("copied_bytes", 64'(copied_bytes), 64'(want_seg.copied));
          check_field("size_bytes", 64'(size_bytes), 64'(want_seg.size));
          check_field("last", 64'(last), 64'(want_seg.last));
        end
      end
      if (start && !busy) predict_command(command, frag_address, byte_count);
    end
    outstanding <= seg_expected.size();
  end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Command stimulus for the scatter-gather fragment list: a directed pass over
// empty and zero-size fragments, address wrap, pad segments and unused
// codes, then random fill/rewind/copy/extract sequences with random
// gaps. The checker beside the block predicts and compares; this module
// drives commands and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 16;
  localparam int LW           = 24;
  localparam int AW           = 32;
  localparam int RANDOM_ITEMS = 185;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 150;

  localparam logic [sgfl_pkg::CMD_BITS-1:0] CMD_RSVD_A = 3'd6;
  localparam logic [sgfl_pkg::CMD_BITS-1:0] CMD_RSVD_B = 3'd7;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [sgfl_pkg::CMD_BITS-1:0] command;
  logic [AW-1:0]                 frag_address;
  logic [LW-1:0]                 byte_count;
  logic                          result_valid;
  logic                          accepted;
  logic [AW-1:0]                 seg_address;
  logic [LW-1:0]                 seg_length;
  logic                          seg_is_pad;
  logic [$clog2(SLOTS+1)-1:0]    entries_left;
  logic [LW-1:0]                 copied_bytes;
  logic [sgfl_pkg::TOTAL_BITS-1:0] size_bytes;
  logic                          last;
  int                            fail_count;
  int                            outstanding;
  int                            cycle_count;
  int                            sent;
  bit                            burst;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  scatter_gather_fragment_list #(
    .SLOTS        (SLOTS),
    .LENGTH_BITS  (LW),
    .ADDRESS_BITS (AW)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .frag_address (frag_address),
    .byte_count   (byte_count),
    .result_valid (result_valid),
    .accepted     (accepted),
    .seg_address  (seg_address),
    .seg_length   (seg_length),
    .seg_is_pad   (seg_is_pad),
    .entries_left (entries_left),
    .copied_bytes (copied_bytes),
    .size_bytes   (size_bytes),
    .last         (last)
  );

  sgfl_segment_checker #(
    .SLOTS        (SLOTS),
    .LENGTH_BITS  (LW),
    .ADDRESS_BITS (AW)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .frag_address (frag_address),
    .byte_count   (byte_count),
    .result_valid (result_valid),
    .accepted     (accepted),
    .seg_address  (seg_address),
    .seg_length   (seg_length),
    .seg_is_pad   (seg_is_pad),
    .entries_left (entries_left),
    .copied_bytes (copied_bytes),
    .size_bytes   (size_bytes),
    .last         (last),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (burst || r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [AW-1:0] pick_addr();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r < 3) return 32'hFFFF_FF00 | AW'($urandom_range(0, 255));
    return AW'($urandom);
  endfunction

  function automatic logic [LW-1:0] pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return LW'($urandom);
    return LW'($urandom_range(1, 48));
  endfunction

  function automatic logic [LW-1:0] pick_want();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return LW'($urandom);
    return LW'($urandom_range(1, 160));
  endfunction

  task automatic send(logic [sgfl_pkg::CMD_BITS-1:0] op, logic [AW-1:0] a,
                      logic [LW-1:0] n);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    command      <= op;
    frag_address <= a;
    byte_count   <= n;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // hold off until every predicted result has come back
  task automatic drain_wait();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    int fill;
    rst          = 1'b1;
    start        = 1'b0;
    command      = sgfl_pkg::CMD_CLEAR;
    frag_address = '0;
    byte_count   = '0;
    sent         = 0;
    burst        = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send(sgfl_pkg::CMD_COPY, '0, '0);
    send(sgfl_pkg::CMD_COPY, '0, 24'd5);
    send(sgfl_pkg::CMD_EXTRACT, '0, '0);
    send(sgfl_pkg::CMD_APPEND, '0, 24'd10);
    send(sgfl_pkg::CMD_APPEND, 32'h0000_1000, '0);
    send(sgfl_pkg::CMD_APPEND, 32'hFFFF_FFF0, 24'h20);
    send(sgfl_pkg::CMD_APPEND, 32'h0000_0001, 24'hFF_FFFF);
    send(sgfl_pkg::CMD_INSERT, 32'hA5A5_5A5A, 24'd3);
    send(sgfl_pkg::CMD_INSERT, '0, 24'd5);
    send(sgfl_pkg::CMD_REWIND, '0, '0);
    send(sgfl_pkg::CMD_COPY, '0, 24'h10);
    send(sgfl_pkg::CMD_COPY, '0, 24'hFF_FFFF);
    send(sgfl_pkg::CMD_EXTRACT, '0, '0);
    send(sgfl_pkg::CMD_REWIND, '0, '0);
    send(sgfl_pkg::CMD_EXTRACT, '0, '0);
    send(sgfl_pkg::CMD_EXTRACT, '0, '0);
    send(sgfl_pkg::CMD_CLEAR, '0, '0);
    send(sgfl_pkg::CMD_APPEND, 32'hFFFF_FFFF, 24'd10);
    send(sgfl_pkg::CMD_COPY, '0, 24'd4);
    send(sgfl_pkg::CMD_EXTRACT, '0, '0);
    send(CMD_RSVD_A, '1, '1);
    send(CMD_RSVD_B, 32'h5A5A_A5A5, 24'h5A_A5A5);
    send(sgfl_pkg::CMD_CLEAR, '1, '1);
    drain_wait();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) send(sgfl_pkg::CMD_CLEAR, pick_addr(), pick_len());
      fill = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 8);
      repeat (fill) begin
        if ($urandom_range(0, 3) == 0) send(sgfl_pkg::CMD_INSERT, pick_addr(), pick_len());
        else send(sgfl_pkg::CMD_APPEND, pick_addr(), pick_len());
      end
      send(sgfl_pkg::CMD_REWIND, AW'($urandom), pick_len());
      if ($urandom_range(0, 5) == 0) begin
        repeat (18) send(sgfl_pkg::CMD_EXTRACT, AW'($urandom), LW'($urandom));
      end
      repeat ($urandom_range(4, 20)) begin
        r = $urandom_range(0, 99);
        if (r < 38) send(sgfl_pkg::CMD_COPY, AW'($urandom), pick_want());
        else if (r < 62) send(sgfl_pkg::CMD_EXTRACT, AW'($urandom), LW'($urandom));
        else if (r < 72) send(sgfl_pkg::CMD_APPEND, pick_addr(), pick_len());
        else if (r < 82) send(sgfl_pkg::CMD_INSERT, pick_addr(), pick_len());
        else if (r < 90) send(sgfl_pkg::CMD_REWIND, AW'($urandom), LW'($urandom));
        else if (r < 95) send(sgfl_pkg::CMD_CLEAR, AW'($urandom), LW'($urandom));
        else if (r < 97) send(CMD_RSVD_A, AW'($urandom), LW'($urandom));
        else send(CMD_RSVD_B, AW'($urandom), LW'($urandom));
      end
      if ($urandom_range(0, 3) == 0) drain_wait();
    end

    drain_wait();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
